@@ rtl/core/seeded_permutation_shuffle_assert.svh @@
// Assertion macros shared by the seeded permutation shuffle RTL.
`ifndef SEEDED_PERMUTATION_SHUFFLE_ASSERT_SVH
`define SEEDED_PERMUTATION_SHUFFLE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("seeded_permutation_shuffle: check failed");
// Next-cycle implication, disabled while reset is asserted.
`define SPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("seeded_permutation_shuffle: check failed");
`else
`define SPS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SPS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/sps_pkg.sv @@
// Package with the types, constants and microcode program of the permutation shuffle.
package sps_pkg;

  // Sizes of the permutation store and of the configuration fields.
  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned PC_W        = 4;

  // Generator constants.
  localparam logic [31:0] WEYL_STEP = 32'h9E37_79B9;
  localparam logic [31:0] MIX_MUL_A = 32'h21F0_AAAD;
  localparam logic [31:0] MIX_MUL_B = 32'h735A_2D97;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_VALUE  = 2'd1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_RANGE     = 2'd1;
  localparam logic [1:0] STATUS_NOT_BUILT = 2'd2;

  typedef logic [PC_W-1:0] pc_t;

  // Microcode step addresses.
  localparam pc_t ST_IDLE     = 4'd0;
  localparam pc_t ST_DISPATCH = 4'd1;
  localparam pc_t ST_BCHK     = 4'd2;
  localparam pc_t ST_FILL     = 4'd3;
  localparam pc_t ST_SETUP    = 4'd4;
  localparam pc_t ST_DRAW     = 4'd5;
  localparam pc_t ST_MIX1     = 4'd6;
  localparam pc_t ST_MIX2     = 4'd7;
  localparam pc_t ST_PICK     = 4'd8;
  localparam pc_t ST_SWAP_I   = 4'd9;
  localparam pc_t ST_SWAP_J   = 4'd10;
  localparam pc_t ST_FIN      = 4'd11;
  localparam pc_t ST_ERR      = 4'd12;
  localparam pc_t ST_RD0      = 4'd13;
  localparam pc_t ST_RD1      = 4'd14;

  // Generator operations.
  typedef enum logic [2:0] {
    GEN_HOLD,
    GEN_SEED,
    GEN_STEP,
    GEN_MIX1,
    GEN_MIX2
  } gen_op_e;

  // Store port operations.
  typedef enum logic [2:0] {
    RAM_NONE,
    RAM_RD_IDX,
    RAM_RD_I,
    RAM_RD_X,
    RAM_WR_K,
    RAM_WR_I,
    RAM_WR_J
  } ram_op_e;

  // Index and holding register operations.
  typedef enum logic [2:0] {
    REG_NONE,
    REG_K_CLR,
    REG_K_INC,
    REG_I_LOAD,
    REG_I_DEC,
    REG_A_LOAD,
    REG_J_LOAD
  } reg_op_e;

  // Result operations.
  typedef enum logic [1:0] {
    RESP_NONE,
    RESP_READ,
    RESP_BUILT,
    RESP_RANGE
  } resp_e;

  // Jump conditions; when the condition is false the step counter advances.
  typedef enum logic [3:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_NO_ITEM,
    JC_IS_READ,
    JC_BAD_COUNT,
    JC_K_NOT_LAST,
    JC_ONE_ENTRY,
    JC_REJECT,
    JC_I_NOT_ONE
  } cond_e;

  // One control word of the program.
  typedef struct packed {
    logic    accept;
    gen_op_e gen_op;
    ram_op_e ram_op;
    reg_op_e reg_op;
    resp_e   resp;
    cond_e   cond;
    pc_t     target;
  } uc_word_t;

  // Status from the datapath that the jump conditions test.
  typedef struct packed {
    logic in_valid;
    logic is_read;
    logic bad_count;
    logic k_not_last;
    logic one_entry;
    logic reject;
    logic i_not_one;
    logic out_blocked;
  } sps_flags_t;

  localparam uc_word_t UC_NOP = '{
    accept: 1'b0, gen_op: GEN_HOLD, ram_op: RAM_NONE, reg_op: REG_NONE,
    resp: RESP_NONE, cond: JC_NEVER, target: ST_IDLE
  };

  function automatic uc_word_t uc(input logic acc, input gen_op_e g, input ram_op_e r,
                                  input reg_op_e q, input resp_e s, input cond_e c,
                                  input pc_t t);
    uc_word_t w;
    w = '{accept: acc, gen_op: g, ram_op: r, reg_op: q, resp: s, cond: c, target: t};
    return w;
  endfunction

  // The program: build walks fill, setup and the draw/swap loop; read is two steps.
  function automatic uc_word_t ucode_rom(input pc_t pc);
    uc_word_t w;
    w = UC_NOP;
    unique case (pc)
      ST_IDLE:     w = uc(1'b1, GEN_HOLD, RAM_NONE,   REG_NONE,   RESP_NONE,  JC_NO_ITEM,
                          ST_IDLE);
      ST_DISPATCH: w = uc(1'b0, GEN_HOLD, RAM_NONE,   REG_NONE,   RESP_NONE,  JC_IS_READ,
                          ST_RD0);
      ST_BCHK:     w = uc(1'b0, GEN_HOLD, RAM_NONE,   REG_K_CLR,  RESP_NONE,  JC_BAD_COUNT,
                          ST_ERR);
      ST_FILL:     w = uc(1'b0, GEN_HOLD, RAM_WR_K,   REG_K_INC,  RESP_NONE,  JC_K_NOT_LAST,
                          ST_FILL);
      ST_SETUP:    w = uc(1'b0, GEN_SEED, RAM_NONE,   REG_I_LOAD, RESP_NONE,  JC_ONE_ENTRY,
                          ST_FIN);
      ST_DRAW:     w = uc(1'b0, GEN_STEP, RAM_RD_I,   REG_NONE,   RESP_NONE,  JC_NEVER,
                          ST_IDLE);
      ST_MIX1:     w = uc(1'b0, GEN_MIX1, RAM_NONE,   REG_A_LOAD, RESP_NONE,  JC_NEVER,
                          ST_IDLE);
      ST_MIX2:     w = uc(1'b0, GEN_MIX2, RAM_NONE,   REG_NONE,   RESP_NONE,  JC_NEVER,
                          ST_IDLE);
      ST_PICK:     w = uc(1'b0, GEN_HOLD, RAM_RD_X,   REG_J_LOAD, RESP_NONE,  JC_REJECT,
                          ST_DRAW);
      ST_SWAP_I:   w = uc(1'b0, GEN_HOLD, RAM_WR_I,   REG_NONE,   RESP_NONE,  JC_NEVER,
                          ST_IDLE);
      ST_SWAP_J:   w = uc(1'b0, GEN_HOLD, RAM_WR_J,   REG_I_DEC,  RESP_NONE,  JC_I_NOT_ONE,
                          ST_DRAW);
      ST_FIN:      w = uc(1'b0, GEN_HOLD, RAM_NONE,   REG_NONE,   RESP_BUILT, JC_ALWAYS,
                          ST_IDLE);
      ST_ERR:      w = uc(1'b0, GEN_HOLD, RAM_NONE,   REG_NONE,   RESP_RANGE, JC_ALWAYS,
                          ST_IDLE);
      ST_RD0:      w = uc(1'b0, GEN_HOLD, RAM_RD_IDX, REG_NONE,   RESP_NONE,  JC_NEVER,
                          ST_IDLE);
      ST_RD1:      w = uc(1'b0, GEN_HOLD, RAM_NONE,   REG_NONE,   RESP_READ,  JC_ALWAYS,
                          ST_IDLE);
      default:     w = uc(1'b0, GEN_HOLD, RAM_NONE,   REG_NONE,   RESP_NONE,  JC_ALWAYS,
                          ST_IDLE);
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/seeded_permutation_shuffle.sv @@
// Seeded permutation shuffle: builds a random permutation of 0..count-1 and reads entries.
// Read: the dispatch step, then RD0 reads the store and RD1 writes the result register.
// Build of n entries: range check, fill, setup, then for each position from n-1 down to 1
// one or more generator draws and a swap; a draw is one add and two registered multiplies, a swap two writes.
// One item at a time; the next item is accepted while the last result waits to be taken.
// Reset clears control, the generator and the built flag; the store is not cleared.
`include "seeded_permutation_shuffle_assert.svh"
module seeded_permutation_shuffle (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           kind_i,
  input  logic [sps_pkg::IDX_W-1:0]      entry_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sps_pkg::IDX_W-1:0]      entry_value_o,
  output logic [1:0]                     status_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sps_pkg::*;

  uc_word_t   ctrl;
  sps_flags_t flags;

  logic [CNT_W-1:0] cfg_count_q;
  logic [31:0]      cfg_seed_q;
  logic             built_q;
  logic [CNT_W-1:0] built_count_q;
  logic             kind_q;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] k_q;
  logic [IDX_W-1:0] i_q;
  logic [IDX_W-1:0] j_q;
  logic [IDX_W-1:0] a_q;
  logic             out_valid_q;
  logic [IDX_W-1:0] entry_value_q;
  logic [1:0]       status_q;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [IDX_W-1:0] ram_rdata;
  logic [IDX_W-1:0] pick;
  logic             reject;
  logic [IDX_W-1:0] resp_value;
  logic [1:0]       resp_status;
  logic             in_fire;

  assign in_ready_o  = ctrl.accept;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count_q <= CNT_W'(1);
      cfg_seed_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ENTRY_COUNT: cfg_count_q <= cfg_data_i[CNT_W-1:0];
        REG_SEED_VALUE:  cfg_seed_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Sequencer status.
  assign flags.in_valid    = in_valid_i;
  assign flags.is_read     = kind_q;
  assign flags.bad_count   = (cfg_count_q == '0) || (cfg_count_q > CNT_W'(MAX_ENTRIES));
  assign flags.k_not_last  = ((CNT_W'(k_q) + CNT_W'(1)) != cfg_count_q);
  assign flags.one_entry   = (cfg_count_q == CNT_W'(1));
  assign flags.reject      = reject;
  assign flags.i_not_one   = (i_q != IDX_W'(1));
  assign flags.out_blocked = out_valid_q && !out_ready_i;

  sps_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  sps_gen u_gen (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (ctrl.gen_op),
    .seed_i   (cfg_seed_q),
    .top_i    (i_q),
    .pick_o   (pick),
    .reject_o (reject)
  );

  // Store port steering.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = k_q;
    ram_wdata = k_q;
    ram_re    = 1'b0;
    ram_raddr = i_q;
    unique case (ctrl.ram_op)
      RAM_NONE: ;
      RAM_RD_IDX: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q;
      end
      RAM_RD_I: begin
        ram_re    = 1'b1;
        ram_raddr = i_q;
      end
      RAM_RD_X: begin
        ram_re    = 1'b1;
        ram_raddr = pick;
      end
      RAM_WR_K: begin
        ram_we    = 1'b1;
        ram_waddr = k_q;
        ram_wdata = k_q;
      end
      RAM_WR_I: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = ram_rdata;
      end
      RAM_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = a_q;
      end
      default: ;
    endcase
  end

  sps_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Item latch and the fill, index and holding registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= kind_i;
      idx_q  <= entry_index_i;
    end
    case (ctrl.reg_op)
      REG_K_CLR:  k_q <= '0;
      REG_K_INC:  k_q <= k_q + IDX_W'(1);
      REG_I_LOAD: i_q <= IDX_W'(cfg_count_q - CNT_W'(1));
      REG_I_DEC:  i_q <= i_q - IDX_W'(1);
      REG_A_LOAD: a_q <= ram_rdata;
      REG_J_LOAD: j_q <= pick;
      default: ;
    endcase
  end

  // Result value and status for the current result step.
  always_comb begin
    resp_value  = '0;
    resp_status = STATUS_OK;
    case (ctrl.resp)
      RESP_READ: begin
        if (!built_q) begin
          resp_status = STATUS_NOT_BUILT;
        end else if (CNT_W'(idx_q) >= built_count_q) begin
          resp_status = STATUS_RANGE;
        end else begin
          resp_value = ram_rdata;
        end
      end
      RESP_RANGE: resp_status = STATUS_RANGE;
      default: ;
    endcase
  end

  // Built flag and count, updated when a build completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      built_q       <= 1'b0;
      built_count_q <= '0;
    end else if (ctrl.resp == RESP_BUILT) begin
      built_q       <= 1'b1;
      built_count_q <= cfg_count_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.resp != RESP_NONE) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.resp != RESP_NONE) begin
      entry_value_q <= resp_value;
      status_q      <= resp_status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign entry_value_o = entry_value_q;
  assign status_o      = status_q;

  // A refused item never carries a nonzero value.
  `SPS_ASSERT_IMP(a_refused_zero, clk_i, rst_ni,
                  out_valid_o && (status_o != STATUS_OK), entry_value_o == '0)
  // Not-built reports stay consistent with the built flag.
  `SPS_ASSERT_IMP(a_not_built, clk_i, rst_ni,
                  out_valid_o && (status_o == STATUS_NOT_BUILT), !built_q)
  // After an item is taken the sequencer leaves its idle step.
  `SPS_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_fire, !in_ready_o)
  // The swap partner never lies above the current position.
  `SPS_ASSERT_IMP(a_swap_order, clk_i, rst_ni, ctrl.ram_op == RAM_WR_J, j_q <= i_q)

endmodule

@@ rtl/core/sps_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module sps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sps_gen.sv @@
// Weyl-sequence generator with a two-round multiply mixer and masked draw.
module sps_gen (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sps_pkg::gen_op_e          op_i,
  input  logic [31:0]               seed_i,
  input  logic [sps_pkg::IDX_W-1:0] top_i,
  output logic [sps_pkg::IDX_W-1:0] pick_o,
  output logic                      reject_o
);
  import sps_pkg::*;

  logic [31:0]      gen_q;
  logic [31:0]      gen_d;
  logic [31:0]      z_q;
  logic [31:0]      z_d;
  logic [31:0]      mix1_in;
  logic [31:0]      mix2_in;
  logic [31:0]      z_final;
  logic [IDX_W-1:0] mask;

  // Generator state: loaded from the seed, stepped once per draw.
  always_comb begin
    gen_d = gen_q;
    case (op_i)
      GEN_SEED: gen_d = seed_i;
      GEN_STEP: gen_d = gen_q + WEYL_STEP;
      default:  gen_d = gen_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= '0;
    end else begin
      gen_q <= gen_d;
    end
  end

  // Mixer rounds, one multiply per step with the product registered.
  assign mix1_in = gen_q ^ (gen_q >> 16);
  assign mix2_in = z_q ^ (z_q >> 15);

  always_comb begin
    z_d = z_q;
    case (op_i)
      GEN_MIX1: z_d = mix1_in * MIX_MUL_A;
      GEN_MIX2: z_d = mix2_in * MIX_MUL_B;
      default:  z_d = z_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    z_q <= z_d;
  end

  // Smear the top index into an all-ones mask and test the masked draw.
  always_comb begin
    for (int b = 0; b < IDX_W; b++) begin
      mask[b] = |(top_i >> b);
    end
  end

  assign z_final  = z_q ^ (z_q >> 15);
  assign pick_o   = z_final[IDX_W-1:0] & mask;
  assign reject_o = (pick_o > top_i);

endmodule

@@ rtl/core/sps_seq.sv @@
// Microcode sequencer: step counter, program table and conditional jumps.
module sps_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sps_pkg::sps_flags_t flags_i,
  output sps_pkg::uc_word_t   ctrl_o
);
  import sps_pkg::*;

  pc_t      pc_q;
  pc_t      pc_d;
  uc_word_t rom_word;
  logic     stall;
  logic     taken;

  assign rom_word = ucode_rom(pc_q);

  // A result step waits while the output register holds an untaken item.
  assign stall = (rom_word.resp != RESP_NONE) && flags_i.out_blocked;

  // Jump condition select.
  always_comb begin
    taken = 1'b0;
    unique case (rom_word.cond)
      JC_NEVER:      taken = 1'b0;
      JC_ALWAYS:     taken = 1'b1;
      JC_NO_ITEM:    taken = !flags_i.in_valid;
      JC_IS_READ:    taken = flags_i.is_read;
      JC_BAD_COUNT:  taken = flags_i.bad_count;
      JC_K_NOT_LAST: taken = flags_i.k_not_last;
      JC_ONE_ENTRY:  taken = flags_i.one_entry;
      JC_REJECT:     taken = flags_i.reject;
      JC_I_NOT_ONE:  taken = flags_i.i_not_one;
      default:       taken = 1'b1;
    endcase
  end

  // Next step address.
  always_comb begin
    if (stall) begin
      pc_d = pc_q;
    end else if (taken) begin
      pc_d = rom_word.target;
    end else begin
      pc_d = pc_q + pc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  // A stalled step issues no datapath operation.
  assign ctrl_o = stall ? UC_NOP : rom_word;

endmodule
